/* rtl/llsw_pkg.sv */
// Shared types and constants for the link-loss safety watchdog.
// Used by the configuration registers, the event evaluator and the top level.
// No dependencies.
package llsw_pkg;

    // Event codes carried on the input tuser field.
    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_PACKET     = 3'd1,
        OP_COMMAND    = 3'd2,
        OP_CONNECT    = 3'd3,
        OP_DISCONNECT = 3'd4
    } op_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_ACTIVE_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_IDLE_TIMEOUT   = 3'd1;
    localparam logic [2:0] REG_CONNECT_GRACE  = 3'd2;
    localparam logic [2:0] REG_CONFIRM_NEEDED = 3'd3;
    localparam logic [2:0] REG_QUEUE_LIMIT    = 3'd4;

    localparam logic [15:0] ACTIVE_TIMEOUT_RST = 16'd2000;
    localparam logic [15:0] IDLE_TIMEOUT_RST   = 16'd500;
    localparam logic [15:0] CONNECT_GRACE_RST  = 16'd3000;
    localparam logic [7:0]  CONFIRM_NEEDED_RST = 8'd3;
    localparam logic [7:0]  QUEUE_LIMIT_RST    = 8'd15;

    localparam logic [7:0]  COUNT_MAX = 8'hFF;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    typedef struct packed {
        logic [15:0] active_timeout_ms;
        logic [15:0] idle_timeout_ms;
        logic [15:0] connect_grace_ms;
        logic [7:0]  confirm_needed;
        logic [7:0]  queue_free_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] now_ms;
        logic        laser_on;
        logic [7:0]  queue_free;
    } item_t;

    typedef struct packed {
        logic       shutdown;
        logic       timeout_latched;
        logic [7:0] overrun_count;
        logic       activity_seen;
    } result_t;

endpackage

/* rtl/llsw_cfg_regs.sv */
// Configuration register file of the link-loss safety watchdog.
// Depends on llsw_pkg for the register indexes, reset values and cfg_t.
module llsw_cfg_regs
    import llsw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [15:0] wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_ACTIVE_TIMEOUT: cfg_next.active_timeout_ms = wr_data;
                REG_IDLE_TIMEOUT:   cfg_next.idle_timeout_ms   = wr_data;
                REG_CONNECT_GRACE:  cfg_next.connect_grace_ms  = wr_data;
                REG_CONFIRM_NEEDED: cfg_next.confirm_needed    = wr_data[7:0];
                REG_QUEUE_LIMIT:    cfg_next.queue_free_limit  = wr_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_timeout_ms <= ACTIVE_TIMEOUT_RST;
            cfg_reg.idle_timeout_ms   <= IDLE_TIMEOUT_RST;
            cfg_reg.connect_grace_ms  <= CONNECT_GRACE_RST;
            cfg_reg.confirm_needed    <= CONFIRM_NEEDED_RST;
            cfg_reg.queue_free_limit  <= QUEUE_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/llsw_eval.sv */
// Event evaluator of the link-loss safety watchdog: link state registers and
// the single-pass logic that turns one event into one result.
// Depends on llsw_pkg for op_t, cfg_t, item_t and result_t.
module llsw_eval
    import llsw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    logic [31:0] last_packet_time_reg,  last_packet_time_next;
    logic [31:0] last_command_time_reg, last_command_time_next;
    logic [31:0] connect_time_reg,      connect_time_next;
    logic        link_up_reg,           link_up_next;
    logic        handled_reg,           handled_next;
    logic        pkt_since_conn_reg,    pkt_since_conn_next;
    logic [7:0]  overrun_reg,           overrun_next;

    logic [31:0] since_connect;
    logic [31:0] since_packet;
    logic [31:0] since_command;
    logic [31:0] limit;
    logic [7:0]  overrun_inc;
    logic        in_grace;
    logic        packet_recent;
    logic        command_recent;
    logic        active;
    logic        fire;

    assign since_connect = item.now_ms - connect_time_reg;
    assign since_packet  = item.now_ms - last_packet_time_reg;
    assign since_command = item.now_ms - last_command_time_reg;

    assign in_grace = !pkt_since_conn_reg &&
                      (since_connect <= {16'd0, cfg.connect_grace_ms});
    assign packet_recent  = (last_packet_time_reg != 32'd0) &&
                            (since_packet < {16'd0, cfg.active_timeout_ms});
    assign command_recent = (last_command_time_reg != 32'd0) &&
                            (since_command < {16'd0, cfg.active_timeout_ms});

    // The count saturates, so it is at least one after any overrun.
    assign overrun_inc = (overrun_reg == COUNT_MAX) ? COUNT_MAX : overrun_reg + 8'd1;

    always_comb
    begin
        last_packet_time_next  = last_packet_time_reg;
        last_command_time_next = last_command_time_reg;
        connect_time_next      = connect_time_reg;
        link_up_next           = link_up_reg;
        handled_next           = handled_reg;
        pkt_since_conn_next    = pkt_since_conn_reg;
        overrun_next           = overrun_reg;
        active                 = 1'b0;
        fire                   = 1'b0;
        limit                  = {16'd0, cfg.idle_timeout_ms};

        case (op_t'(item.operation))
            OP_TICK:
            begin
                if (link_up_reg && !handled_reg && !in_grace)
                begin
                    active = packet_recent || item.laser_on ||
                             (item.queue_free < cfg.queue_free_limit) || command_recent;
                    limit  = active ? {16'd0, cfg.active_timeout_ms}
                                    : {16'd0, cfg.idle_timeout_ms};
                    if (since_packet > limit)
                    begin
                        overrun_next = overrun_inc;
                        if (overrun_inc >= cfg.confirm_needed)
                        begin
                            fire         = 1'b1;
                            handled_next = 1'b1;
                        end
                    end
                    else
                    begin
                        overrun_next = 8'd0;
                    end
                end
                else
                begin
                    overrun_next = 8'd0;
                end
            end
            OP_PACKET:
            begin
                last_packet_time_next = item.now_ms;
                pkt_since_conn_next   = 1'b1;
                handled_next          = 1'b0;
                overrun_next          = 8'd0;
            end
            OP_COMMAND:
            begin
                last_command_time_next = item.now_ms;
            end
            OP_CONNECT:
            begin
                link_up_next           = 1'b1;
                connect_time_next      = item.now_ms;
                last_packet_time_next  = item.now_ms;
                last_command_time_next = item.now_ms;
                pkt_since_conn_next    = 1'b0;
                handled_next           = 1'b0;
                overrun_next           = 8'd0;
            end
            OP_DISCONNECT:
            begin
                link_up_next        = 1'b0;
                pkt_since_conn_next = 1'b0;
                handled_next        = 1'b0;
                overrun_next        = 8'd0;
            end
            default:
            begin
                overrun_next = overrun_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_packet_time_reg  <= 32'd0;
            last_command_time_reg <= 32'd0;
            connect_time_reg      <= 32'd0;
            link_up_reg           <= 1'b0;
            handled_reg           <= 1'b0;
            pkt_since_conn_reg    <= 1'b0;
            overrun_reg           <= 8'd0;
        end
        else if (step)
        begin
            last_packet_time_reg  <= last_packet_time_next;
            last_command_time_reg <= last_command_time_next;
            connect_time_reg      <= connect_time_next;
            link_up_reg           <= link_up_next;
            handled_reg           <= handled_next;
            pkt_since_conn_reg    <= pkt_since_conn_next;
            overrun_reg           <= overrun_next;
        end
    end

    assign res.shutdown        = fire;
    assign res.timeout_latched = handled_next;
    assign res.overrun_count   = overrun_next;
    assign res.activity_seen   = active;

endmodule

/* rtl/link_loss_safety_watchdog_core.sv */
// Top level of the link-loss safety watchdog: stream ports, input register,
// result register and the configuration write channel.
// Depends on llsw_pkg, llsw_cfg_regs and llsw_eval.

// The watchdog takes one event per item (check tick, link packet, command,
// connect or disconnect) with a millisecond timestamp and returns exactly one
// result per item. An accepted item lands in an input register; in the next
// cycle that it can move on, the evaluator updates the link state and writes
// the result register in one pass. Throughput is one item per clock cycle while
// results are taken; the single-pass state update in the evaluator is what sets
// that rate. While a result waits, the input register can still take one more
// item; after that the input side stalls until the waiting result is taken.
// Configuration writes are accepted in every cycle and must be issued only while
// no item is in flight. After reset, all stored timestamps are zero and the link
// is taken as down.
module link_loss_safety_watchdog_core
    import llsw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Bits from lowest up: now_ms[31:0], laser_on[32], queue_free[40:33], zero pad.
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // Event code: operation[2:0].
    input  logic [2:0]             s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Bits from lowest up: shutdown[0], timeout_latched[1], overrun_count[9:2],
    // activity_seen[10], zero pad.
    output logic [OUT_TDATA_W-1:0] m_tdata,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;

    // The held item moves to the result register when that register is empty
    // or its current result is being taken this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    llsw_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    llsw_eval u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.operation  <= s_tuser;
            item_reg.now_ms     <= s_tdata[31:0];
            item_reg.laser_on   <= s_tdata[32];
            item_reg.queue_free <= s_tdata[40:33];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, res_reg.activity_seen, res_reg.overrun_count,
                       res_reg.timeout_latched, res_reg.shutdown};

endmodule

/* verif/tb_link_loss_safety_watchdog_core.sv */
// Self-checking testbench for link_loss_safety_watchdog_core: directed and random event
// streams with random stalls on both stream sides, checked against a scoreboard predictor.
// Depends on llsw_pkg and the core RTL only.
module tb_link_loss_safety_watchdog_core;
    import llsw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY   = 2;
    localparam int SETTLE_CYCLES  = PIPE_LATENCY + 4;
    localparam int LIMIT_CYCLES   = 1_000_000;
    // The result side holds off once, long enough to back the core up completely.
    localparam int BACKLOG_AT     = 400;
    localparam int BACKLOG_CYCLES = 300;

    // Predicts the status word for every accepted event and holds the
    // predictions in arrival order until the core delivers its results.
    class shutdown_tracker;
        cfg_t        regs;
        logic [31:0] packet_stamp;
        logic [31:0] command_stamp;
        logic [31:0] connect_stamp;
        bit          link_up;
        bit          handled;
        bit          packet_since_connect;
        logic [7:0]  overrun_ticks;
        result_t     pending[$];
        int          error_count;

        function new();
            regs.active_timeout_ms = ACTIVE_TIMEOUT_RST;
            regs.idle_timeout_ms   = IDLE_TIMEOUT_RST;
            regs.connect_grace_ms  = CONNECT_GRACE_RST;
            regs.confirm_needed    = CONFIRM_NEEDED_RST;
            regs.queue_free_limit  = QUEUE_LIMIT_RST;
            packet_stamp  = '0;
            command_stamp = '0;
            connect_stamp = '0;
            link_up       = 1'b0;
            clear_link_flags();
            error_count   = 0;
        endfunction

        function void set_register(logic [2:0] index, logic [15:0] value);
            case (index)
                REG_ACTIVE_TIMEOUT: regs.active_timeout_ms = value;
                REG_IDLE_TIMEOUT:   regs.idle_timeout_ms   = value;
                REG_CONNECT_GRACE:  regs.connect_grace_ms  = value;
                REG_CONFIRM_NEEDED: regs.confirm_needed    = value[7:0];
                REG_QUEUE_LIMIT:    regs.queue_free_limit  = value[7:0];
                default: ;
            endcase
        endfunction

        // A zero stamp never counts as recent.
        function bit is_recent(logic [31:0] now_ms, logic [31:0] stamp);
            logic [31:0] age;
            age = now_ms - stamp;
            return (stamp != '0) && (age < {16'd0, regs.active_timeout_ms});
        endfunction

        function void clear_link_flags();
            packet_since_connect = 1'b0;
            handled              = 1'b0;
            overrun_ticks        = '0;
        endfunction

        function void note_event(logic [2:0] op_code, logic [31:0] now_ms,
                                 logic laser_on, logic [7:0] queue_free);
            result_t     status;
            logic [31:0] limit_ms;
            logic [31:0] since_connect;
            logic [31:0] silence;
            bit          fire;
            bit          active;
            fire          = 1'b0;
            active        = 1'b0;
            since_connect = now_ms - connect_stamp;
            silence       = now_ms - packet_stamp;
            case (op_code)
                OP_TICK: begin
                    if (!link_up || handled) begin
                        overrun_ticks = '0;
                    end else if (!packet_since_connect &&
                                 since_connect <= {16'd0, regs.connect_grace_ms}) begin
                        overrun_ticks = '0;
                    end else begin
                        active = is_recent(now_ms, packet_stamp) || laser_on ||
                                 (queue_free < regs.queue_free_limit) ||
                                 is_recent(now_ms, command_stamp);
                        limit_ms = active ? {16'd0, regs.active_timeout_ms}
                                          : {16'd0, regs.idle_timeout_ms};
                        if (silence > limit_ms) begin
                            if (overrun_ticks != COUNT_MAX)
                                overrun_ticks = overrun_ticks + 8'd1;
                            if (overrun_ticks >= regs.confirm_needed) begin
                                fire    = 1'b1;
                                handled = 1'b1;
                            end
                        end else begin
                            overrun_ticks = '0;
                        end
                    end
                end
                OP_PACKET: begin
                    packet_stamp = now_ms;
                    clear_link_flags();
                    packet_since_connect = 1'b1;
                end
                OP_COMMAND: begin
                    command_stamp = now_ms;
                end
                OP_CONNECT: begin
                    link_up       = 1'b1;
                    connect_stamp = now_ms;
                    packet_stamp  = now_ms;
                    command_stamp = now_ms;
                    clear_link_flags();
                end
                OP_DISCONNECT: begin
                    link_up = 1'b0;
                    clear_link_flags();
                end
                default: ;
            endcase
            status.shutdown        = fire;
            status.timeout_latched = handled;
            status.overrun_count   = overrun_ticks;
            status.activity_seen   = active;
            pending.push_back(status);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                error_count++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_status(logic [15:0] word);
            result_t want;
            if (pending.size() == 0) begin
                error_count++;
                $display("%0t: result 0x%h arrived with no expected value,",
                         $time, word);
                $display("    expected none, actual 0x%h", word);
                return;
            end
            want = pending.pop_front();
            compare_field("shutdown",        {7'd0, want.shutdown},        {7'd0, word[0]});
            compare_field("timeout_latched", {7'd0, want.timeout_latched}, {7'd0, word[1]});
            compare_field("overrun_count",   want.overrun_count,           word[9:2]);
            compare_field("activity_seen",   {7'd0, want.activity_seen},   {7'd0, word[10]});
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [2:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [2:0]             cfg_index = '0;
    logic [15:0]            cfg_data  = '0;

    shutdown_tracker tracker = new();

    // Millisecond clock seen by the random event stream.
    logic [31:0] wall_ms      = 32'h0000_1000;
    bit          feed_calm    = 1'b0;
    bit          sink_calm    = 1'b0;
    int          results_seen = 0;

    link_loss_safety_watchdog_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int draw_gap(bit calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(25, 80);
    endfunction

    // Offers one item, records it at acceptance, then idles for a random gap.
    // Valid is only lowered when a gap follows, so back-to-back items keep it high.
    task automatic post_event(input logic [2:0] op_code, input logic [31:0] now_ms,
                              input logic laser_on, input logic [7:0] queue_free);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op_code;
        s_tdata  <= {7'd0, queue_free, laser_on, now_ms};
        do @(posedge clk); while (!s_tready);
        tracker.note_event(op_code, now_ms, laser_on, queue_free);
        gap = draw_gap(feed_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering and waits until every predicted result has been checked.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_register(index, value);
    endtask

    // Only called with no item in flight; the 8-bit registers sometimes get random upper data bits.
    task automatic apply_settings(input logic [15:0] active_ms, input logic [15:0] idle_ms,
                                  input logic [15:0] grace_ms, input logic [15:0] confirm,
                                  input logic [15:0] queue_limit);
        write_register(REG_ACTIVE_TIMEOUT, active_ms);
        write_register(REG_IDLE_TIMEOUT, idle_ms);
        write_register(REG_CONNECT_GRACE, grace_ms);
        write_register(REG_CONFIRM_NEEDED, confirm);
        write_register(REG_QUEUE_LIMIT, queue_limit);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly plausible link traffic on an advancing clock: connects, packets,
    // commands and plenty of ticks, so silences build up and shutdowns fire.
    // A few items are noise with any code, including unused ones, and any time.
    task automatic run_traffic(input int count, input int advance_max);
        int          kind;
        logic [2:0]  op_code;
        logic [31:0] stamp;
        logic        laser_on;
        logic [7:0]  queue_free;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0)
                feed_calm = ($urandom_range(0, 3) == 0);
            kind       = $urandom_range(0, 99);
            wall_ms    = wall_ms + $urandom_range(0, advance_max);
            stamp      = wall_ms;
            laser_on   = ($urandom_range(0, 3) == 0);
            queue_free = 8'($urandom_range(0, 255));
            if (kind < 4)
                op_code = OP_CONNECT;
            else if (kind < 6)
                op_code = OP_DISCONNECT;
            else if (kind < 16)
                op_code = OP_PACKET;
            else if (kind < 24)
                op_code = OP_COMMAND;
            else if (kind < 92)
                op_code = OP_TICK;
            else begin
                op_code = 3'($urandom_range(0, 7));
                stamp   = $urandom();
            end
            post_event(op_code, stamp, laser_on, queue_free);
        end
    endtask

    // Result side: checks every accepted result and stalls at random, with one
    // long hold-off that lets the core fill up and push back on its input.
    initial begin : result_sink
        int hold_left;
        int pause;
        hold_left = 0;
        pause     = 0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                tracker.check_status(m_tdata);
                results_seen++;
                if (results_seen % 80 == 0)
                    sink_calm = ($urandom_range(0, 2) == 0);
                if (results_seen == BACKLOG_AT)
                    hold_left = BACKLOG_CYCLES;
                else
                    pause = draw_gap(sink_calm);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (pause > 0) begin
                pause--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : run_limit
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] active_ms;
        logic [15:0] idle_ms;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk at the reset settings (active 2000, idle 500, grace 3000,
        // confirm 3, queue limit 15).
        post_event(OP_TICK, 32'd0, 1'b1, 8'd0);             // tick with the link down
        post_event(3'($urandom_range(5, 7)), $urandom(), 1'b1, 8'd255);
        post_event(3'($urandom_range(5, 7)), $urandom(), 1'b0, 8'd0);
        post_event(3'($urandom_range(5, 7)), $urandom(), 1'b1, 8'd128);
        post_event(OP_PACKET, 32'd50, 1'b0, 8'd255);        // packet while down
        post_event(OP_COMMAND, 32'd60, 1'b0, 8'd255);
        post_event(OP_CONNECT, 32'd100, 1'b1, 8'd255);
        post_event(OP_TICK, 32'd1000, 1'b0, 8'd255);        // inside grace
        post_event(OP_TICK, 32'd3100, 1'b0, 8'd255);        // last grace millisecond
        post_event(OP_TICK, 32'd3101, 1'b0, 8'd255);        // idle overrun
        post_event(OP_TICK, 32'd3200, 1'b1, 8'd255);        // active through the laser
        post_event(OP_TICK, 32'd3300, 1'b0, 8'd0);          // busy queue, shutdown fires
        post_event(OP_TICK, 32'd3400, 1'b0, 8'd255);        // handled, count clears
        post_event(OP_PACKET, 32'd3500, 1'b0, 8'd255);      // rearms
        post_event(OP_TICK, 32'd3600, 1'b0, 8'd255);
        post_event(OP_COMMAND, 32'd3700, 1'b0, 8'd255);
        post_event(OP_TICK, 32'd4100, 1'b0, 8'd255);        // active through a recent packet and a command
        post_event(OP_DISCONNECT, 32'd4200, 1'b1, 8'd0);
        post_event(OP_TICK, 32'd5000, 1'b1, 8'd0);
        // Time differences across the 32-bit wrap.
        post_event(OP_CONNECT, 32'hFFFF_FF00, 1'b0, 8'd14);
        post_event(OP_PACKET, 32'hFFFF_FFFF, 1'b0, 8'd255);
        post_event(OP_TICK, 32'h0000_0200, 1'b0, 8'd200);
        post_event(OP_TICK, 32'h0000_0900, 1'b0, 8'd255);
        // Connecting at time zero leaves every stamp at zero, so nothing is recent.
        post_event(OP_CONNECT, 32'd0, 1'b1, 8'd255);
        post_event(OP_TICK, 32'hFFFF_FFFF, 1'b0, 8'd255);
        wait_drained();

        // Short limits so silences overrun quickly.
        apply_settings(16'd40, 16'd10, 16'd60, {8'($urandom()), 8'd3},
                       {8'($urandom()), 8'd15});
        wall_ms = $urandom();
        run_traffic(100, 12);
        wait_drained();

        // Everything at zero; a confirm count of zero fires on the first overrun.
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_traffic(80, 3);
        wait_drained();

        // Everything at its maximum, with the clock wrapping during the phase.
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        wall_ms = 32'hFFF8_0000;
        run_traffic(80, 30000);
        wait_drained();

        // Two random settings; the long result hold-off falls in here.
        repeat (2) begin
            active_ms = 16'($urandom_range(5, 200));
            idle_ms   = 16'($urandom_range(1, 100));
            apply_settings(active_ms, idle_ms, 16'($urandom_range(0, 150)),
                           {8'($urandom()), 8'($urandom_range(1, 5))},
                           {8'($urandom()), 8'($urandom_range(0, 255))});
            wall_ms = $urandom();
            run_traffic(130, idle_ms / 2 + active_ms / 8 + 2);
            wait_drained();
        end

        // Unbroken silence until the count climbs all the way to 255 and fires.
        apply_settings(16'd10, 16'd5, 16'd0, 16'd255, 16'd0);
        wall_ms = $urandom();
        post_event(OP_CONNECT, wall_ms, 1'b0, 8'd255);
        for (int n = 0; n < 258; n++) begin
            wall_ms = wall_ms + 32'd20;
            post_event(OP_TICK, wall_ms, 1'b0, 8'($urandom_range(0, 255)));
        end
        wait_drained();

        if (tracker.error_count == 0 && tracker.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
